// ===== sv/gbrw_pkg.sv =====
// gbrw_pkg: shared types and constants for the grid cell walker
// no dependencies
`default_nettype none
package gbrw_pkg;
  localparam int MAX_STEPS_DEF  = 64;
  localparam int CELL_SHIFT_DEF = 23;
  localparam int FRAC_WIDTH_DEF = 16;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_WIDTH    = 2'd2;
  localparam logic [1:0] REG_HEIGHT   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_DIVX, ST_MULX, ST_DIVY, ST_MULY, ST_WALK
  } state_t;

  // request to the shared divider
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

// ===== sv/gbrw_div.sv =====
// gbrw_div: saturating signed fixed-point divider, one quotient bit per cycle
// depends on gbrw_pkg
`default_nettype none
module gbrw_div #(
  parameter int FRAC_WIDTH = gbrw_pkg::FRAC_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gbrw_pkg::div_req_t req,
  output gbrw_pkg::div_rsp_t      rsp
);
  localparam int NW = 32 + FRAC_WIDTH;
  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW:0]   rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [32:0]   den_r, den_nxt;
  logic          neg_r, neg_nxt;
  logic          done_r, done_nxt;
  logic [31:0]   res_r, res_nxt;

  logic [NW:0]   trial;
  logic [32:0]   mn;
  logic [32:0]   dmag;

  always_comb begin
    mn   = req.num[31] ? (33'd0 - {1'b1, req.num}) : {1'b0, req.num};
    dmag = req.den[31] ? (33'd0 - {1'b1, req.den}) : {1'b0, req.den};
    trial = {rem_r[NW-1:0], num_r[NW-1]};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      num_nxt  = NW'({mn, {FRAC_WIDTH{1'b0}}});
      rem_nxt  = '0;
      quo_nxt  = '0;
      den_nxt  = dmag;
      neg_nxt  = req.num[31];
    end else if (busy_r) begin
      if (den_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = neg_r ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        num_nxt = num_r << 1;
        if (trial >= (NW+1)'(den_r)) begin
          rem_nxt = trial - (NW+1)'(den_r);
          quo_nxt = {quo_r[NW-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          quo_nxt = {quo_r[NW-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
          if (neg_r) begin
            if (quo_nxt >= NW'(33'h0_8000_0000)) res_nxt = 32'h8000_0000;
            else res_nxt = 32'd0 - quo_nxt[31:0];
          end else begin
            if (quo_nxt > NW'(33'h0_7fff_ffff)) res_nxt = 32'h7fff_ffff;
            else res_nxt = quo_nxt[31:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign rsp = {done_r, res_r};

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !busy_nxt && !req.start) |=> done_r) else $error("divider lost result");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider busy at done");
endmodule
`default_nettype wire

// ===== sv/grid_block_ray_walker.sv =====
// grid_block_ray_walker: top level of the 2d grid cell walker
// depends on gbrw_pkg and gbrw_div
//
// usage:
//   in_ channel: one beat carries a segment's two 16.16 endpoints
//   out_ channel: one beat per visited cell, in walk order, last flags the
//     final cell of the segment; at most MAX_STEPS beats per segment
//   cfg_ port: write-only grid origin and size, written while idle
// timing:
//   one segment occupies the block from accept to its last out beat
//   setup is a prep state, two serial divides and two multiply states (a
//   divide is skipped when its axis stays in one cell), then per cell a
//   load step and an out beat that holds while the receiver stalls
//   the bit-serial divider sets the setup length
// reset: synchronous active low, clears control and configuration to zero
// stall: the walk holds its current cell in the output register until the
//   receiver takes it; in_stall stays high for the whole segment
`default_nettype none
module grid_block_ray_walker #(
  parameter int MAX_STEPS  = gbrw_pkg::MAX_STEPS_DEF,
  parameter int CELL_SHIFT = gbrw_pkg::CELL_SHIFT_DEF,
  parameter int FRAC_WIDTH = gbrw_pkg::FRAC_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_start_x,
  input  wire logic [31:0] in_start_y,
  input  wire logic [31:0] in_end_x,
  input  wire logic [31:0] in_end_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [9:0]       out_cell_x,
  output logic [9:0]       out_cell_y,
  output logic             out_inside_map,
  output logic             out_last
);
  localparam int BTOFRAC = CELL_SHIFT - FRAC_WIDTH;
  localparam int SCW     = $clog2(MAX_STEPS + 1);
  // signed cell coordinate width: start cell range plus room for the walk
  localparam int TW      = 34 - CELL_SHIFT + SCW;
  localparam logic [31:0] UNIT     = 32'(64'd1 << FRAC_WIDTH);
  localparam logic [31:0] CMASK    = 32'((64'd1 << CELL_SHIFT) - 1);
  localparam logic [31:0] BIG_STEP = 32'(64'd256 << FRAC_WIDTH);

  // configuration
  logic [31:0] org_x_r, org_y_r;
  logic [8:0]  width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r <= '0; org_y_r <= '0; width_r <= '0; height_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gbrw_pkg::REG_ORIGIN_X: org_x_r  <= cfg_data;
        gbrw_pkg::REG_ORIGIN_Y: org_y_r  <= cfg_data;
        gbrw_pkg::REG_WIDTH:    width_r  <= cfg_data[8:0];
        gbrw_pkg::REG_HEIGHT:   height_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  gbrw_pkg::state_t state_r, state_nxt;

  // working registers
  logic [31:0] x1_r, y1_r, x2_r, y2_r;
  logic [31:0] px_r, py_r, xs_r, ys_r, xint_r, yint_r;
  logic signed [TW-1:0] mx_r, my_r, gx_r, gy_r;
  logic [1:0]  dx_r, dy_r;
  logic [SCW-1:0] k_r;
  logic signed [63:0] prod_r;
  logic        ov_r;
  logic [9:0]  ocx_r, ocy_r;
  logic        oin_r, olast_r;

  gbrw_pkg::div_req_t dreq;
  gbrw_pkg::div_rsp_t drsp;

  gbrw_div #(.FRAC_WIDTH(FRAC_WIDTH)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp)
  );

  wire in_acc  = in_valid && !in_stall;
  wire out_acc = out_valid && !out_stall;

  // start nudge and origin shift, done on the accepted beat
  logic [31:0] sx_n, sy_n;
  always_comb begin
    sx_n = in_start_x;
    sy_n = in_start_y;
    if (((in_start_x - org_x_r) & CMASK) == '0) sx_n = in_start_x + UNIT;
    if (((in_start_y - org_y_r) & CMASK) == '0) sy_n = in_start_y + UNIT;
  end

  // cell coordinates (arithmetic shift of wrapped differences)
  wire signed [TW-1:0] xt1 = TW'($signed(x1_r) >>> CELL_SHIFT);
  wire signed [TW-1:0] yt1 = TW'($signed(y1_r) >>> CELL_SHIFT);
  wire signed [TW-1:0] xt2 = TW'($signed(x2_r) >>> CELL_SHIFT);
  wire signed [TW-1:0] yt2 = TW'($signed(y2_r) >>> CELL_SHIFT);
  wire [31:0] frx = 32'($signed(x1_r) >>> BTOFRAC) & (UNIT - 32'd1);
  wire [31:0] fry = 32'($signed(y1_r) >>> BTOFRAC) & (UNIT - 32'd1);
  wire [31:0] bx  = 32'($signed(x1_r) >>> BTOFRAC);
  wire [31:0] by  = 32'($signed(y1_r) >>> BTOFRAC);

  // walk step decision
  wire signed [31:0] mx_w = 32'(mx_r);
  wire signed [31:0] my_w = 32'(my_r);
  wire at_goal = (mx_r == gx_r) && (my_r == gy_r);
  wire fin     = at_goal || (k_r == SCW'(MAX_STEPS - 1));
  wire y_hit = (($signed(yint_r) >>> FRAC_WIDTH) == my_w);
  wire x_hit = (($signed(xint_r) >>> FRAC_WIDTH) == mx_w);
  wire [31:0] prod_sh = 32'(prod_r >>> FRAC_WIDTH);
  wire cell_in_map = (mx_w >= 0) && (my_w >= 0) &&
                     (mx_w < $signed({23'd0, width_r})) &&
                     (my_w < $signed({23'd0, height_r}));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gbrw_pkg::ST_IDLE: if (in_acc) state_nxt = gbrw_pkg::ST_PREP;
      gbrw_pkg::ST_PREP: state_nxt = gbrw_pkg::ST_DIVX;
      gbrw_pkg::ST_DIVX: if (drsp.done || xt2 == xt1) state_nxt = gbrw_pkg::ST_MULX;
      gbrw_pkg::ST_MULX: state_nxt = gbrw_pkg::ST_DIVY;
      gbrw_pkg::ST_DIVY: if ((drsp.done && !ov_r) || (yt2 == yt1 && !ov_r))
                           state_nxt = gbrw_pkg::ST_MULY;
      gbrw_pkg::ST_MULY: state_nxt = gbrw_pkg::ST_WALK;
      gbrw_pkg::ST_WALK: if (ov_r && olast_r && out_acc) state_nxt = gbrw_pkg::ST_IDLE;
      default: state_nxt = gbrw_pkg::ST_IDLE;
    endcase
  end

  // divider requests
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = y2_r - y1_r;
    dreq.den   = x2_r - x1_r;
    case (state_r)
      gbrw_pkg::ST_PREP: dreq.start = (xt2 != xt1);
      gbrw_pkg::ST_MULX: begin
        dreq.start = (yt2 != yt1);
        dreq.num   = x2_r - x1_r;
        dreq.den   = y2_r - y1_r;
      end
      default: ;
    endcase
  end

  // ov_r: in DIVY it marks the divide start cycle; in WALK, an out beat pending
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gbrw_pkg::ST_IDLE;
      ov_r    <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        gbrw_pkg::ST_MULX: ov_r <= 1'b1;
        gbrw_pkg::ST_DIVY: ov_r <= 1'b0;
        gbrw_pkg::ST_MULY: begin
          ov_r <= 1'b0;
          k_r  <= '0;
        end
        gbrw_pkg::ST_WALK: begin
          if (!ov_r) begin
            ov_r <= 1'b1;
          end else if (out_acc) begin
            ov_r <= 1'b0;
            k_r  <= k_r + SCW'(1);
          end
        end
        default: ov_r <= 1'b0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      gbrw_pkg::ST_IDLE: if (in_acc) begin
        x1_r <= sx_n - org_x_r;
        y1_r <= sy_n - org_y_r;
        x2_r <= in_end_x - org_x_r;
        y2_r <= in_end_y - org_y_r;
      end
      gbrw_pkg::ST_PREP: begin
        gx_r <= xt2; gy_r <= yt2; mx_r <= xt1; my_r <= yt1;
        if (xt2 > xt1)      begin dx_r <= 2'b01; px_r <= UNIT - frx; end
        else if (xt2 < xt1) begin dx_r <= 2'b11; px_r <= frx; end
        else                begin dx_r <= 2'b00; px_r <= UNIT; end
        if (yt2 > yt1)      begin dy_r <= 2'b01; py_r <= UNIT - fry; end
        else if (yt2 < yt1) begin dy_r <= 2'b11; py_r <= fry; end
        else                begin dy_r <= 2'b00; py_r <= UNIT; end
      end
      gbrw_pkg::ST_DIVX: begin
        if (dx_r == 2'b00) ys_r <= BIG_STEP;
        else if (drsp.done) ys_r <= drsp.quo;
        prod_r <= $signed(px_r) * $signed((dx_r == 2'b00) ? BIG_STEP : drsp.quo);
      end
      gbrw_pkg::ST_MULX: yint_r <= by + prod_sh;
      gbrw_pkg::ST_DIVY: if (!ov_r) begin
        if (dy_r == 2'b00) xs_r <= BIG_STEP;
        else if (drsp.done) xs_r <= drsp.quo;
        prod_r <= $signed(py_r) * $signed((dy_r == 2'b00) ? BIG_STEP : drsp.quo);
      end
      gbrw_pkg::ST_MULY: xint_r <= bx + prod_sh;
      gbrw_pkg::ST_WALK: begin
        if (!ov_r) begin
          // load the out register with the current cell, then advance
          ocx_r   <= 10'(mx_r);
          ocy_r   <= 10'(my_r);
          oin_r   <= cell_in_map;
          olast_r <= fin;
          if (!fin) begin
            if (y_hit) begin
              yint_r <= yint_r + ys_r;
              mx_r   <= mx_r + TW'($signed(dx_r));
            end else if (x_hit) begin
              xint_r <= xint_r + xs_r;
              my_r   <= my_r + TW'($signed(dy_r));
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign in_stall       = (state_r != gbrw_pkg::ST_IDLE);
  assign out_valid      = (state_r == gbrw_pkg::ST_WALK) && ov_r;
  assign out_cell_x     = ocx_r;
  assign out_cell_y     = ocy_r;
  assign out_inside_map = oin_r;
  assign out_last       = olast_r;

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_last) |=> (state_r == gbrw_pkg::ST_IDLE)) else $error("walk did not end");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != gbrw_pkg::ST_IDLE) |-> in_stall) else $error("input open while busy");
  a_step_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (k_r < SCW'(MAX_STEPS))) else $error("step limit passed");
  a_cap_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && k_r == SCW'(MAX_STEPS - 1)) |-> out_last) else $error("missing last");
endmodule
`default_nettype wire

// ===== bench/gbrw_checker.sv =====
// gbrw_checker: watches the walker's channels, predicts every cell beat and compares
// depends on gbrw_pkg for the geometry constants and register indexes
module gbrw_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_start_x,
  input  logic [31:0] in_start_y,
  input  logic [31:0] in_end_x,
  input  logic [31:0] in_end_y,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_cell_x,
  input  logic [9:0]  out_cell_y,
  input  logic        out_inside_map,
  input  logic        out_last,
  output int          fail_count,
  output int          cells_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CSH       = gbrw_pkg::CELL_SHIFT_DEF;
  localparam int          FW        = gbrw_pkg::FRAC_WIDTH_DEF;
  localparam int          MAX_STEPS = gbrw_pkg::MAX_STEPS_DEF;
  localparam logic [31:0] UNIT      = 32'(1) << FW;
  localparam logic [31:0] FMASK     = UNIT - 1;
  localparam logic [31:0] CELL_MASK = (32'(1) << CSH) - 1;

  typedef struct {
    logic [9:0] cx;
    logic [9:0] cy;
    logic       in_map;
    logic       last;
  } cell_beat_t;

  cell_beat_t  expected_cells[$];
  logic [31:0] org_x, org_y;
  logic [8:0]  map_w, map_h;

  assign cells_pending = expected_cells.size();

  function automatic logic [31:0] slope_div(logic [31:0] num, longint unsigned den);
    longint          n;
    longint unsigned mn, q;
    n  = longint'($signed(num));
    mn = (n < 0) ? -n : n;
    if (den == 0) return (n < 0) ? 32'h8000_0000 : 32'h7fff_ffff;
    q = (mn << FW) / den;
    if (n < 0) begin
      if (q >= 64'h8000_0000) return 32'h8000_0000;
      return 32'd0 - q[31:0];
    end
    if (q > 64'h7fff_ffff) return 32'h7fff_ffff;
    return q[31:0];
  endfunction

  function automatic logic [31:0] fx_mul(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    p = p >>> FW;
    return p[31:0];
  endfunction

  // direction, distance to the first edge and the other axis's slope
  function automatic void axis_setup(input logic [31:0] a1, a2, input longint t1, t2,
                                     input logic [31:0] other, output int dir,
                                     output logic [31:0] partial, slope);
    longint      d, fr;
    logic [31:0] diff;
    diff = a2 - a1;
    d    = longint'($signed(diff));
    fr   = (longint'($signed(a1)) >>> (CSH - FW)) & longint'(FMASK);
    if (t2 > t1) begin
      dir = 1; partial = UNIT - 32'(fr); slope = slope_div(other, (d < 0) ? -d : d);
    end else if (t2 < t1) begin
      dir = -1; partial = 32'(fr); slope = slope_div(other, (d < 0) ? -d : d);
    end else begin
      // stationary axis: full unit partial, fixed big slope
      dir = 0; partial = UNIT; slope = 32'(256) << FW;
    end
  endfunction

  function automatic void predict_walk(logic [31:0] sx, sy, ex, ey);
    logic [31:0] x1, y1, x2, y2, px, py, ys, xs, yint, xint, tmp;
    longint      xt1, yt1, xt2, yt2, mx, my;
    int          dx, dy;
    logic        fin;
    cell_beat_t  b;
    // a start sitting on a cell edge gets nudged one unit
    if (((sx - org_x) & CELL_MASK) == 0) sx += UNIT;
    if (((sy - org_y) & CELL_MASK) == 0) sy += UNIT;
    x1 = sx - org_x; y1 = sy - org_y;
    x2 = ex - org_x; y2 = ey - org_y;
    xt1 = longint'($signed(x1)) >>> CSH;
    yt1 = longint'($signed(y1)) >>> CSH;
    xt2 = longint'($signed(x2)) >>> CSH;
    yt2 = longint'($signed(y2)) >>> CSH;
    axis_setup(x1, x2, xt1, xt2, y2 - y1, dx, px, ys);
    tmp  = 32'(longint'($signed(y1)) >>> (CSH - FW));
    yint = tmp + fx_mul(px, ys);
    axis_setup(y1, y2, yt1, yt2, x2 - x1, dy, py, xs);
    tmp  = 32'(longint'($signed(x1)) >>> (CSH - FW));
    xint = tmp + fx_mul(py, xs);
    mx = xt1; my = yt1;
    for (int k = 0; k < MAX_STEPS; k++) begin
      fin = (mx == xt2 && my == yt2) || (k == MAX_STEPS - 1);
      b.cx     = mx[9:0];
      b.cy     = my[9:0];
      b.in_map = (mx >= 0 && mx < longint'(map_w) && my >= 0 && my < longint'(map_h));
      b.last   = fin;
      expected_cells.push_back(b);
      if (fin) break;
      if ((longint'($signed(yint)) >>> FW) == my) begin
        yint += ys; mx += dx;
      end else if ((longint'($signed(xint)) >>> FW) == mx) begin
        xint += xs; my += dy;
      end
      // otherwise the same cell repeats until the step limit
    end
  endfunction

  task automatic report_mismatch(string what, logic [9:0] got, logic [9:0] want);
    $display("%0t: cell beat mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    cell_beat_t e;
    if (!rst_n) begin
      org_x <= '0; org_y <= '0; map_w <= '0; map_h <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gbrw_pkg::REG_ORIGIN_X: org_x <= cfg_data;
          gbrw_pkg::REG_ORIGIN_Y: org_y <= cfg_data;
          gbrw_pkg::REG_WIDTH:    map_w <= cfg_data[8:0];
          gbrw_pkg::REG_HEIGHT:   map_h <= cfg_data[8:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_walk(in_start_x, in_start_y, in_end_x, in_end_y);
      if (out_valid && !out_stall) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: cell beat with nothing expected", $realtime);
          fail_count++;
        end else begin
          e = expected_cells.pop_front();
          if (out_cell_x !== e.cx) report_mismatch("cell_x", out_cell_x, e.cx);
          if (out_cell_y !== e.cy) report_mismatch("cell_y", out_cell_y, e.cy);
          if (out_inside_map !== e.in_map)
            report_mismatch("inside_map", 10'(out_inside_map), 10'(e.in_map));
          if (out_last !== e.last) report_mismatch("last", 10'(out_last), 10'(e.last));
        end
      end
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// tb_top: stimulus and verdict for the grid cell walker
// depends on grid_block_ray_walker, gbrw_pkg and gbrw_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         IDLE_LIMIT   = 5000;
  localparam logic [31:0] CELL        = 32'h0080_0000;  // one cell side in 16.16

  logic        clk, rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_stall;
  logic [31:0] in_start_x, in_start_y, in_end_x, in_end_y;
  logic        out_valid, out_stall;
  logic [9:0]  out_cell_x, out_cell_y;
  logic        out_inside_map, out_last;
  int          fail_count, cells_pending;
  int          idle_cycles;
  bit          stall_quiet;
  int          stall_left;
  logic [31:0] cur_org_x, cur_org_y;

  grid_block_ray_walker dut (.*);
  gbrw_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // receiver: random stall bursts, mostly short, now and then long, with quiet stretches
  initial begin
    out_stall  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1;
        stall_left--;
      end else begin
        out_stall = 0;
        if (!stall_quiet && $urandom_range(0, 5) == 0)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
      end
    end
  end

  // watchdog: too long with no beat on any port means a hang
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  // drain all walks, let the block settle, then load a new grid
  task automatic load_grid(logic [31:0] ox, logic [31:0] oy, logic [8:0] w, logic [8:0] h);
    in_valid = 0;
    wait (cells_pending == 0);
    repeat (20) @(negedge clk);
    write_reg(gbrw_pkg::REG_ORIGIN_X, ox);
    write_reg(gbrw_pkg::REG_ORIGIN_Y, oy);
    write_reg(gbrw_pkg::REG_WIDTH, 32'(w));
    write_reg(gbrw_pkg::REG_HEIGHT, 32'(h));
    cur_org_x = ox;
    cur_org_y = oy;
  endtask

  // one segment beat; called at a falling edge, returns at a falling edge
  task automatic send_segment(logic [31:0] sx, sy, ex, ey);
    int gap;
    gap = ($urandom_range(0, 2) == 0) ? (($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                                  : $urandom_range(1, 3)) : 0;
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    in_start_x = sx; in_start_y = sy; in_end_x = ex; in_end_y = ey;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    @(negedge clk);
  endtask

  // mostly short random walks near the origin, plus edge starts, axis-aligned walks and noise
  task automatic random_segments(int count);
    logic [31:0] sx, sy, ex, ey;
    int          kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(0, 9);
      sx = cur_org_x + 32'($signed($urandom_range(0, 40 * 128) - 20 * 128)) * 32'h1_0000
           + $urandom_range(0, 32'hffff);
      sy = cur_org_y + 32'($signed($urandom_range(0, 40 * 128) - 20 * 128)) * 32'h1_0000
           + $urandom_range(0, 32'hffff);
      if (kind == 0) begin
        // start right on a cell corner
        sx = cur_org_x + CELL * $urandom_range(0, 20);
        sy = cur_org_y + CELL * $urandom_range(0, 20);
      end
      ex = sx + 32'($signed($urandom_range(0, 16 * 128) - 8 * 128)) * 32'h1_0000
           + $urandom_range(0, 32'hffff);
      ey = sy + 32'($signed($urandom_range(0, 16 * 128) - 8 * 128)) * 32'h1_0000
           + $urandom_range(0, 32'hffff);
      if (kind == 1) ey = sy;  // horizontal
      if (kind == 2) ex = sx;  // vertical
      if (kind >= 8) begin
        sx = $urandom; sy = $urandom; ex = $urandom; ey = $urandom;
      end
      send_segment(sx, sy, ex, ey);
    end
  endtask

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = gbrw_pkg::REG_ORIGIN_X; cfg_data = '0;
    in_valid = 0; in_start_x = '0; in_start_y = '0; in_end_x = '0; in_end_y = '0;
    stall_quiet = 0; cur_org_x = '0; cur_org_y = '0;
    repeat (12) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // directed: small map at the origin
    load_grid(32'h0, 32'h0, 9'd16, 9'd16);
    send_segment(32'h0, 32'h0, 32'h0, 32'h0);                         // corner start, same cell
    send_segment(32'h0010_0000, 32'h0010_0000, 32'h0020_0000, 32'h0020_0000);
    send_segment(32'h0010_0000, 32'h0010_0000, 32'h0400_0000, 32'h0010_0000); // horizontal
    send_segment(32'h0010_0000, 32'h0010_0000, 32'h0010_0000, 32'h0400_0000); // vertical
    send_segment(32'h0410_0000, 32'h0410_0000, 32'h0010_0000, 32'h0010_0000); // both down
    send_segment(32'h0010_0000, 32'h0010_0000, 32'h0400_0000, 32'h0400_0000); // diagonal
    send_segment(32'h0080_0000, 32'h0123_4567, 32'h0300_0000, 32'h0345_6789); // x on edge
    send_segment(32'hff00_0000, 32'hff80_0000, 32'h00c0_0000, 32'h0050_0000); // negative side
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff); // step limit
    send_segment(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
    send_segment(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001);
    send_segment(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000); // slope overflow
    send_segment(32'h0000_0001, 32'h0234_5678, 32'h7fff_ffff, 32'h0234_5679);
    send_segment(32'h0100_0000, 32'h0100_0000, 32'h0100_0001, 32'hf000_0000); // steep
    send_segment(32'h0000_ffff, 32'h0001_0000, 32'h0fff_0000, 32'h0001_0001);

    // hold off until every cell is out
    in_valid = 0;
    wait (cells_pending == 0);
    @(negedge clk);
    random_segments(60);

    // extremes: origin at the negative limit, full-size map
    load_grid(32'h8000_0000, 32'h8000_0000, 9'd511, 9'd511);
    send_segment(32'h8000_0000, 32'h8000_0000, 32'h8100_0000, 32'h8080_0000);
    stall_quiet = 1;
    random_segments(50);
    stall_quiet = 0;

    load_grid(32'h7fff_ffff, 32'h7fff_ffff, 9'd0, 9'd511);
    random_segments(50);

    load_grid($urandom, $urandom, 9'($urandom), 9'($urandom));
    random_segments(50);

    load_grid(32'hfff0_0000, 32'h0012_3456, 9'd20, 9'd0);
    random_segments(50);

    in_valid = 0;
    wait (cells_pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule
